/* design/wac_pkg.sv */
`default_nettype none

package wac_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 16;
    localparam int PHASE_W    = 32;
    localparam int LEN_W      = 17;
    localparam int STEP_W     = 33;
    localparam int COEF_W     = 18;   // unsigned Q1.17, 0 .. 1.0
    localparam int MAX_LENGTH = 65536;
    localparam int ONE_Q17    = 131072;

    // quarter-wave cosine table: COS_DEPTH + 1 entries
    localparam int COS_LOG2  = 10;
    localparam int COS_DEPTH = 1 << COS_LOG2;
    localparam int COS_AW    = COS_LOG2 + 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // window constants in Q17
    localparam logic [16:0] K_HALF = 17'd65536;
    localparam logic [16:0] K_054  = 17'd70779;
    localparam logic [16:0] K_046  = 17'd60293;
    localparam logic [16:0] K_042  = 17'd55050;
    localparam logic [16:0] K_008  = 17'd10486;

    // APB register map, 64-bit registers at 8-byte spacing
    localparam int ADDR_W = 5;
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;

    localparam logic [1:0]        RST_MODE   = 2'd0;
    localparam logic [LEN_W-1:0]  RST_LENGTH = 17'd1024;
    localparam logic [STEP_W-1:0] RST_STEP   = 33'd4198404;

    typedef enum logic [1:0] {
        WIN_HANN     = 2'd0,
        WIN_HAMMING  = 2'd1,
        WIN_BLACKMAN = 2'd2
    } t_win_mode;

    typedef struct packed {
        logic [1:0]        mode;
        logic [LEN_W-1:0]  length;
        logic [STEP_W-1:0] step;
    } t_cfg;

    typedef struct packed {
        t_win_mode mode;
        logic      neg1;   // first cosine (phase) is negated
        logic      neg2;   // second cosine (double phase) is negated
    } t_cos_ctl;

    typedef logic [COEF_W-1:0] t_cos_tab [0:COS_DEPTH];

    // Taylor series in Q30, evaluated at elaboration only
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab           tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> COS_LOG2;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = $signed(term);
            for (int i = 1; i <= 12; i++) begin
                term = ((term * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
                if (i[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            tab[k] = COEF_W'(($unsigned(sum) + 64'd4096) >> 13);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

/* design/wac_cos_rom.sv */
`default_nettype none

module wac_cos_rom (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [wac_pkg::COS_AW-1:0] i_addr_a,
    input  wire logic [wac_pkg::COS_AW-1:0] i_addr_b,
    output logic      [wac_pkg::COEF_W-1:0] o_data_a,
    output logic      [wac_pkg::COEF_W-1:0] o_data_b
);
    import wac_pkg::*;

    localparam t_cos_tab COS_TAB = build_cos_tab();

    logic [COEF_W-1:0] r_data_a;
    logic [COEF_W-1:0] r_data_b;

    // two read ports, registered output, hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= COS_TAB[i_addr_a];
            r_data_b <= COS_TAB[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

`default_nettype wire

/* design/wac_cfg.sv */
`default_nettype none

module wac_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [wac_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                pwdata,
    output logic      [63:0]                prdata,
    output logic                            pready,
    output wac_pkg::t_cfg                   o_cfg
);
    import wac_pkg::*;

    logic [1:0] w_reg;
    logic       w_wr;
    t_cfg       r_cfg;

    assign w_reg  = paddr[ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= RST_MODE;
            r_cfg.length <= RST_LENGTH;
            r_cfg.step   <= RST_STEP;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_MODE:   r_cfg.mode   <= pwdata[1:0];
                REG_LENGTH: r_cfg.length <= pwdata[LEN_W-1:0];
                REG_STEP:   r_cfg.step   <= pwdata[STEP_W-1:0];
                default:    ;   // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_MODE:   prdata = 64'(r_cfg.mode);
            REG_LENGTH: prdata = 64'(r_cfg.length);
            REG_STEP:   prdata = 64'(r_cfg.step);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/wac_coef.sv */
`default_nettype none

module wac_coef (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wac_pkg::t_cos_ctl               i_ctl,
    input  wire logic [wac_pkg::COEF_W-1:0] i_cos1,
    input  wire logic [wac_pkg::COEF_W-1:0] i_cos2,
    output logic      [wac_pkg::COEF_W-1:0] o_coef
);
    import wac_pkg::*;

    localparam int P_W   = 35;
    localparam int ACC_W = 37;

    logic [16:0]            w_a0;
    logic [16:0]            w_k1;
    logic [16:0]            w_k2;
    logic [P_W-1:0]         r_p1;
    logic [P_W-1:0]         r_p2;
    logic [P_W-1:0]         r_a0;
    logic                   r_neg1;
    logic                   r_neg2;
    logic signed [ACC_W-1:0] w_acc;
    logic [ACC_W-1:0]       w_rnd;
    logic [COEF_W-1:0]      n_coef;
    logic [COEF_W-1:0]      r_coef;

    always_comb begin
        unique case (i_ctl.mode)
            WIN_HAMMING: begin
                w_a0 = K_054;
                w_k1 = K_046;
                w_k2 = '0;
            end
            WIN_BLACKMAN: begin
                w_a0 = K_042;
                w_k1 = K_HALF;
                w_k2 = K_008;
            end
            default: begin
                w_a0 = K_HALF;
                w_k1 = K_HALF;
                w_k2 = '0;
            end
        endcase
    end

    // stage 1: products of table magnitudes and window weights
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= P_W'(w_k1) * P_W'(i_cos1);
            r_p2   <= P_W'(w_k2) * P_W'(i_cos2);
            r_a0   <= P_W'(w_a0) << 17;
            r_neg1 <= i_ctl.neg1;
            r_neg2 <= i_ctl.neg2;
        end
    end

    // stage 2: a0 - a1*cos(ph) + a2*cos(2ph), clamp, round to Q17, clamp
    always_comb begin
        w_acc = $signed({2'b00, r_a0})
              + (r_neg1 ? $signed({2'b00, r_p1}) : -$signed({2'b00, r_p1}))
              + (r_neg2 ? -$signed({2'b00, r_p2}) : $signed({2'b00, r_p2}));
        if (w_acc < 0) begin
            w_rnd = '0;
        end else begin
            w_rnd = ($unsigned(w_acc) + (ACC_W'(1) << 16)) >> 17;
        end
        if (w_rnd > ACC_W'(ONE_Q17)) begin
            n_coef = COEF_W'(ONE_Q17);
        end else begin
            n_coef = w_rnd[COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coef <= n_coef;
        end
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

/* design/window_apply_cosine_sum.sv */
// Cosine-sum window (Hann / Hamming / Blackman) on a sample stream.
// Pipeline from an input beat to its output beat: table read,
// weight products, coefficient, sample product, round and saturate.
// Throughput: one beat per cycle; the whole pipeline stalls on output backpressure.
// Reset (synchronous, active low) clears index, phase and valid flags and loads
// the registers with Hann, length 1024 and step 4198404.
`default_nettype none

module window_apply_cosine_sum (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // slave stream: tdata[15:0] = sample
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [15:0]                s_axis_tdata,
    // master stream: tdata[15:0] = windowed_sample, tlast = last_of_frame
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [15:0]                m_axis_tdata,
    output logic                            m_axis_tlast,
    // APB configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [wac_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                pwdata,
    output logic      [63:0]                prdata,
    output logic                            pready
);
    import wac_pkg::*;

    localparam int PROD_W = SAMPLE_W + COEF_W;

    t_cfg w_cfg;

    wac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Pipeline advance: everything moves when the output register is free
    // or being drained this cycle.
    logic w_adv;
    logic w_acc_in;
    logic r_v1, r_v2, r_v3, r_v4, r_ov;

    assign w_adv         = !r_ov || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc_in      = s_axis_tvalid && w_adv;

    // ---- frame position state ----
    logic [INDEX_W-1:0] r_idx;
    logic [PHASE_W-1:0] r_phase;
    logic [INDEX_W-1:0] w_len_m1;
    logic               w_last;

    // length clamped into [2, MAX_LENGTH], then minus one
    always_comb begin
        if (w_cfg.length < LEN_W'(2)) begin
            w_len_m1 = INDEX_W'(1);
        end else if (w_cfg.length > LEN_W'(MAX_LENGTH)) begin
            w_len_m1 = INDEX_W'(MAX_LENGTH - 1);
        end else begin
            w_len_m1 = INDEX_W'(w_cfg.length - LEN_W'(1));
        end
    end

    // index at or past the frame end (length may drop mid-frame) closes it
    assign w_last = r_idx >= w_len_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_phase <= '0;
        end else if (w_acc_in) begin
            if (w_last) begin
                r_idx   <= '0;
                r_phase <= '0;
            end else begin
                r_idx   <= r_idx + INDEX_W'(1);
                r_phase <= r_phase + w_cfg.step[PHASE_W-1:0];
            end
        end
    end

    // ---- quarter-wave table addressing ----
    // idx = round(low30 * DEPTH / 2^30); odd quadrants mirror, quadrants
    // 1 and 2 negate.
    function automatic logic [COS_AW-1:0] cos_addr(input logic [PHASE_W-1:0] ph);
        logic [30:0]       t;
        logic [COS_AW-1:0] idx;
        t   = {1'b0, ph[29:0]} + (31'(1) << (29 - COS_LOG2));
        idx = t[30:30-COS_LOG2];
        if (ph[30]) begin
            cos_addr = COS_AW'(COS_DEPTH) - idx;
        end else begin
            cos_addr = idx;
        end
    endfunction

    logic [PHASE_W-1:0] w_phase2;
    logic [COS_AW-1:0]  w_addr1;
    logic [COS_AW-1:0]  w_addr2;
    t_cos_ctl           w_ctl;

    assign w_phase2 = {r_phase[PHASE_W-2:0], 1'b0};
    assign w_addr1  = cos_addr(r_phase);
    assign w_addr2  = cos_addr(w_phase2);

    always_comb begin
        unique case (w_cfg.mode)
            2'(WIN_HAMMING):  w_ctl.mode = WIN_HAMMING;
            2'(WIN_BLACKMAN): w_ctl.mode = WIN_BLACKMAN;
            default:          w_ctl.mode = WIN_HANN;   // unused code too
        endcase
        w_ctl.neg1 = r_phase[31] ^ r_phase[30];
        w_ctl.neg2 = w_phase2[31] ^ w_phase2[30];
    end

    // ---- stage 1: table read ----
    logic [COEF_W-1:0] w_cos1;
    logic [COEF_W-1:0] w_cos2;
    t_cos_ctl          r_ctl1;

    wac_cos_rom u_rom (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_addr_a (w_addr1),
        .i_addr_b (w_addr2),
        .o_data_a (w_cos1),
        .o_data_b (w_cos2)
    );

    // ---- stages 2..3: coefficient ----
    logic [COEF_W-1:0] w_coef;

    wac_coef u_coef (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_ctl  (r_ctl1),
        .i_cos1 (w_cos1),
        .i_cos2 (w_cos2),
        .o_coef (w_coef)
    );

    // sample and last flag ride alongside
    logic signed [SAMPLE_W-1:0] r_s1, r_s2, r_s3;
    logic                       r_l1, r_l2, r_l3, r_l4;
    logic signed [PROD_W-1:0]   r_prod;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ctl1 <= w_ctl;
            r_s1   <= $signed(s_axis_tdata);
            r_l1   <= w_last;
            r_s2   <= r_s1;
            r_l2   <= r_l1;
            r_s3   <= r_s2;
            r_l3   <= r_l2;
            // stage 4: sample times coefficient
            r_prod <= PROD_W'(r_s3) * $signed({1'b0, w_coef});
            r_l4   <= r_l3;
        end
    end

    // ---- stage 5: round half up, saturate ----
    logic signed [PROD_W:0]     w_rsum;
    logic signed [PROD_W-17:0]  w_y;
    logic [SAMPLE_W-1:0]        n_out;
    logic [SAMPLE_W-1:0]        r_out;
    logic                       r_out_last;

    always_comb begin
        w_rsum = (PROD_W + 1)'(r_prod) + (PROD_W + 1)'(65536);
        w_y    = w_rsum[PROD_W:17];
        if (w_y > (PROD_W - 16)'(2 ** (SAMPLE_W - 1) - 1)) begin
            n_out = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end else if (w_y < -(PROD_W - 16)'(2 ** (SAMPLE_W - 1))) begin
            n_out = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            n_out = w_y[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out      <= n_out;
            r_out_last <= r_l4;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_out_last;

    // ---- checks ----
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && w_last) |=> (r_idx == '0 && r_phase == '0))
        else $error("frame did not restart after last beat");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && !w_last) |=> (r_idx == $past(r_idx) + INDEX_W'(1)))
        else $error("sample index did not advance");

    a_coef_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (w_coef <= COEF_W'(ONE_Q17)))
        else $error("window coefficient above 1.0");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && r_v4) |=> (r_v4 && r_ov))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

/* bench/tb_window_apply_cosine_sum.sv */
`timescale 1ns / 100ps

module tb_window_apply_cosine_sum;

    import wac_pkg::*;

    // ---------------------------------------------------------------------
    // Bench constants
    // ---------------------------------------------------------------------
    localparam int     STALL_LIMIT  = 4000;   // cycles with no beat anywhere
    localparam int     DRAIN_CYCLES = 12;     // pipeline is 5 deep, plus margin
    localparam int     RAND_PER_RUN = 485;    // random samples per stall profile
    localparam int     MAX_PRINTS   = 40;

    // Window math, Q17 weights, Q30 angle for the cosine table
    localparam int     TAB_DEPTH        = 1024;
    localparam longint GAIN_ONE         = 131072;
    localparam longint W_HALF           = 65536;
    localparam longint W_HAMMING_A0     = 70779;
    localparam longint W_HAMMING_A1     = 60293;
    localparam longint W_BLACKMAN_A0    = 55050;
    localparam longint W_BLACKMAN_A2    = 10486;
    localparam longint QUARTER_TURN_Q30 = 1686629713;
    localparam longint FRAME_MAX        = 65536;
    localparam longint OUT_MAX          = 32767;
    localparam longint OUT_MIN          = -32768;

    // mode code the block does not name; must behave as Hann
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // address slot past the last register; writes there are dropped
    localparam logic [1:0] REG_SPARE   = 2'd3;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } out_beat_t;

    // ---------------------------------------------------------------------
    // Window tracker: own copy of the registers, frame position and phase.
    // Every accepted input beat is turned into the output beat it must cause.
    // ---------------------------------------------------------------------
    class window_tracker;
        int          cos_tab [0:TAB_DEPTH];
        logic [1:0]  mode;
        logic [16:0] length;
        logic [32:0] step;
        logic [15:0] index;
        logic [31:0] phase;
        out_beat_t   pending [$];
        int          errors;
        int          taken;
        int          checked;
        int          frames;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          sum;
            // quarter-wave cosine, Taylor series in Q30, rounded to Q17
            for (int k = 0; k <= TAB_DEPTH; k++) begin
                x    = (longint'(QUARTER_TURN_Q30) * k) / TAB_DEPTH;
                x2   = (x * x) >> 30;
                term = 64'd1 << 30;
                sum  = longint'(term);
                for (int i = 1; i <= 12; i++) begin
                    term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
                    if (i % 2 == 1) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                cos_tab[k] = int'((sum + 4096) >> 13);
            end
            mode    = WIN_HANN;
            length  = 17'd1024;
            step    = 33'd4198404;
            index   = '0;
            phase   = '0;
            errors  = 0;
            taken   = 0;
            checked = 0;
            frames  = 0;
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTS) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
            errors++;
        endtask

        function void write_reg(input logic [1:0] reg_idx, input logic [63:0] value);
            case (reg_idx)
                REG_MODE:   mode   = value[1:0];
                REG_LENGTH: length = value[16:0];
                REG_STEP:   step   = value[32:0];
                default: ;
            endcase
        endfunction

        function longint cos_at(input logic [31:0] ph);
            longint unsigned pos;
            longint unsigned idx;
            pos = longint'(ph[29:0]);
            idx = (pos * TAB_DEPTH + (64'd1 << 29)) >> 30;
            if (idx > TAB_DEPTH) begin
                idx = TAB_DEPTH;
            end
            case (ph[31:30])
                2'd0:    return  cos_tab[idx];
                2'd1:    return -cos_tab[TAB_DEPTH - idx];
                2'd2:    return -cos_tab[idx];
                default: return  cos_tab[TAB_DEPTH - idx];
            endcase
        endfunction

        // window gain at this phase, Q17, clamped to 0 .. 1.0
        function longint gain(input logic [31:0] ph);
            longint c1;
            longint acc;
            c1 = cos_at(ph);
            case (mode)
                WIN_HAMMING: acc = W_HAMMING_A0 * GAIN_ONE - W_HAMMING_A1 * c1;
                WIN_BLACKMAN: begin
                    acc = W_BLACKMAN_A0 * GAIN_ONE - W_HALF * c1
                        + W_BLACKMAN_A2 * cos_at({ph[30:0], 1'b0});
                end
                default:     acc = W_HALF * GAIN_ONE - W_HALF * c1;
            endcase
            if (acc < 0) begin
                acc = 0;   // Blackman dips slightly below zero at the ends
            end
            acc = (acc + 65536) >>> 17;
            if (acc > GAIN_ONE) begin
                acc = GAIN_ONE;
            end
            return acc;
        endfunction

        function void take_sample(input logic [15:0] raw);
            longint    s;
            longint    len;
            longint    y;
            bit        last;
            out_beat_t beat;
            s   = longint'($signed(raw));
            len = longint'(length);
            if (len < 2) begin
                len = 2;
            end
            if (len > FRAME_MAX) begin
                len = FRAME_MAX;
            end
            // also catches an index left beyond a shortened frame
            last = (longint'(index) >= len - 1);
            y    = (s * gain(phase) + 65536) >>> 17;
            if (y > OUT_MAX) begin
                y = OUT_MAX;
            end
            if (y < OUT_MIN) begin
                y = OUT_MIN;
            end
            beat.value = y[15:0];
            beat.last  = last;
            pending.push_back(beat);
            if (last) begin
                index = '0;
                phase = '0;
                frames++;
            end else begin
                index = index + 16'd1;
                phase = phase + step[31:0];
            end
            taken++;
        endfunction

        task check_output(input logic [15:0] data, input logic last);
            out_beat_t want;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("output beat with nothing pending: data %h last %b",
                                 data, last));
                return;
            end
            want = pending.pop_front();
            if (data !== want.value) begin
                report($sformatf("beat %0d windowed sample %h, want %h",
                                 checked - 1, data, want.value));
            end
            if (last !== want.last) begin
                report($sformatf("beat %0d last flag %b, want %b",
                                 checked - 1, last, want.last));
            end
        endtask
    endclass

    // ---------------------------------------------------------------------
    // Signals; every block input starts at a known value
    // ---------------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;   // [15:0] sample
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;         // [15:0] windowed sample
    logic                m_axis_tlast;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [63:0]         pwdata        = '0;
    logic [63:0]         prdata;
    logic                pready;

    window_tracker tracker;
    int            src_idle_pct  = 27;
    int            sink_idle_pct = 60;
    int            reg_writes    = 0;
    int            stall_cycles  = 0;

    always #5ns i_clk = ~i_clk;

    window_apply_cosine_sum u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ---------------------------------------------------------------------
    // Receiver: random backpressure, redrawn every cycle
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Output monitor: values read here are the ones present at the edge,
    // since every bench drive lands in the nonblocking region.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_output(m_axis_tdata, m_axis_tlast);
        end
    end

    // Watchdog: any beat on either stream or a register access keeps it quiet
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no beat for %0d cycles, giving up", $realtime, STALL_LIMIT);
            $display("tb_window_apply_cosine_sum: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers; each task is entered just after a rising edge
    // ---------------------------------------------------------------------

    // One input beat, with random sender gaps in front of it. The beat is
    // handed to the tracker at the edge where tready was seen high.
    task automatic push_sample(input logic [15:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_sample(value);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic apb_write(input logic [1:0] reg_idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(reg_idx, value);
        reg_writes++;
    endtask

    // Stop sending and let the pipeline empty before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // round(2^32 / (len - 1)) for the effective frame length
    function automatic logic [32:0] step_for(input longint len);
        if (len < 2) begin
            len = 2;
        end
        if (len > FRAME_MAX) begin
            len = FRAME_MAX;
        end
        return 33'((((64'd1 << 33) / (len - 1)) + 1) >> 1);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short frames so frame ends come often; extremes now and then
    function automatic logic [16:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 17'd65536;
            1:       return 17'($urandom_range(65537, 131071));
            2:       return 17'($urandom_range(0, 1));
            3:       return 17'($urandom_range(41, 3000));
            default: return 17'($urandom_range(2, 40));
        endcase
    endfunction

    // One random phase: new settings (not always all of them, so a frame can
    // run on across a change), then a burst of samples.
    task automatic random_phase();
        logic [32:0] stp;
        settle();
        if ($urandom_range(0, 9) < 7) begin
            // upper bits are junk on purpose; only the low two count
            apb_write(REG_MODE, {32'($urandom), 32'($urandom)});
        end
        if ($urandom_range(0, 9) < 8) begin
            apb_write(REG_LENGTH, 64'(pick_length()));
        end
        if ($urandom_range(0, 4) == 0) begin
            stp = {1'($urandom_range(0, 1)), 32'($urandom)};
            if (stp == '0) begin
                stp = 33'd1;
            end
        end else begin
            stp = step_for(longint'(tracker.length));
        end
        apb_write(REG_STEP, 64'(stp));
        if ($urandom_range(0, 19) == 0) begin
            apb_write(REG_SPARE, {32'($urandom), 32'($urandom)});
        end
        repeat ($urandom_range(20, 60)) push_sample(pick_sample());
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        logic [15:0] extremes [8];
        int          target;
        extremes = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                     16'h0000, 16'h5555, 16'hAAAA, 16'h7FFF};
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part, first stall profile ---
        // registers straight out of reset: Hann, 1024 samples
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h5555);

        // short Hann frame, crosses a frame end with the full-scale values
        settle();
        apb_write(REG_LENGTH, 64'd8);
        apb_write(REG_STEP, 64'(step_for(8)));
        foreach (extremes[i]) push_sample(extremes[i]);

        // shortest frame, step of a full turn (acts as zero)
        settle();
        apb_write(REG_MODE, 64'(WIN_HAMMING));
        apb_write(REG_LENGTH, 64'd2);
        apb_write(REG_STEP, 64'h1_0000_0000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0001);

        // Blackman: the clamped ends and a peak of full gain
        settle();
        apb_write(REG_MODE, 64'(WIN_BLACKMAN));
        apb_write(REG_LENGTH, 64'd5);
        apb_write(REG_STEP, 64'(step_for(5)));
        repeat (5) push_sample(16'h7FFF);

        // unused mode code, length below the minimum, smallest step
        settle();
        apb_write(REG_MODE, 64'(MODE_UNUSED));
        apb_write(REG_LENGTH, 64'd0);
        apb_write(REG_STEP, 64'd1);
        push_sample(16'hFFFF);
        push_sample(16'h7FFF);
        push_sample(16'h8000);

        // frame shortened under a running index: next beat must end it
        settle();
        apb_write(REG_MODE, 64'(WIN_HANN));
        apb_write(REG_LENGTH, 64'd16);
        apb_write(REG_STEP, 64'(step_for(16)));
        repeat (4) push_sample(16'h4000);
        settle();
        apb_write(REG_LENGTH, 64'd3);
        push_sample(16'h7FFF);
        push_sample(16'h7FFF);

        // write past the register map; nothing may change
        settle();
        apb_write(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        push_sample(16'h7FFF);

        // --- random part over three stall profiles ---
        for (int r = 0; r < 3; r++) begin
            case (r)
                0: begin
                    src_idle_pct  = 27;
                    sink_idle_pct = 60;
                end
                1: begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 27;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            target = tracker.taken + RAND_PER_RUN;
            while (tracker.taken < target) random_phase();
        end

        // wait out every pending beat, then watch for strays
        settle();

        $display("covered %0d samples, %0d output beats, %0d frame ends, %0d register writes",
                 tracker.taken, tracker.checked, tracker.frames, reg_writes);
        $display("all window modes, lengths from 0 to beyond the maximum, three stall profiles");
        if (tracker.errors == 0) begin
            $display("tb_window_apply_cosine_sum: done, clean");
        end else begin
            $display("tb_window_apply_cosine_sum: done, errors");
        end
        $finish;
    end

endmodule
